### hdl/rqbn_pkg.sv
package rqbn_pkg;

  // fraction bits of the per-channel gain and offset
  localparam int unsigned GAIN_FRAC_BITS = 16;

  localparam int unsigned ACC_W    = 32;
  localparam int unsigned MULT_W   = 31;
  localparam int unsigned SHIFT_W  = 6;
  localparam int unsigned INT8_W   = 8;
  localparam int unsigned CFG_AW   = 5;
  localparam int unsigned CFG_DW   = 32;
  localparam int unsigned IN_DW    = 96;
  localparam int unsigned OUT_DW   = 16;
  localparam int unsigned PIPE_DEPTH = 7;

  // product of the int8 conv value and the gain, then plus the offset
  localparam int unsigned BN_PROD_W = INT8_W + ACC_W;
  localparam int unsigned BN_SUM_W  = BN_PROD_W + 1;
  localparam int unsigned BN_RND_W  = BN_SUM_W + 1;

  localparam logic [MULT_W-1:0]  MULT_RST  = MULT_W'(1073741824);
  localparam logic [SHIFT_W-1:0] SHIFT_RST = '0;
  localparam logic [INT8_W-1:0]  ZOFF_RST  = '0;
  localparam logic [INT8_W-1:0]  LOW_RST   = 8'h80;
  localparam logic [INT8_W-1:0]  HIGH_RST  = 8'h7F;

  typedef enum logic [2:0] {
    REG_MULT  = 3'd0,
    REG_SHIFT = 3'd1,
    REG_ZOFF  = 3'd2,
    REG_CLO   = 3'd3,
    REG_CHI   = 3'd4,
    REG_OLO   = 3'd5,
    REG_OHI   = 3'd6
  } rqbn_reg_t;

endpackage

### hdl/requant_batchnorm_epilogue_core.sv
// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+-----------------------------------------------
// in_       | in  | tvalid / tready    | tdata: accumulator, channel_gain, channel_offset
// out_      | out | tvalid / tready    | tdata: conv_value, out_value
// cfg_      | in  | APB psel / penable | seven requant and clamp registers
//
// Seven-stage pipeline: one item per cycle while out_ does not stall; out_tvalid is
// the valid bit of the stage-7 output register, the last stage that the item reaches.
// The two multipliers (accumulator x Q31 multiplier, conv value x gain) each own a stage.
// rst_n is synchronous and clears only the stage valid bits and the registers.
// A stall on out_ freezes every stage at once; in_tready is low exactly while the
// output register holds an item that is not being taken.
module requant_batchnorm_epilogue_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // accumulator [31:0], channel_gain [63:32], channel_offset [95:64]
  input  logic [rqbn_pkg::IN_DW-1:0]        in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // conv_value [7:0], out_value [15:8]
  output logic [rqbn_pkg::OUT_DW-1:0]       out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [rqbn_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [rqbn_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [rqbn_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  localparam int unsigned F = rqbn_pkg::GAIN_FRAC_BITS;

  // ---------------- configuration registers ----------------
  logic [rqbn_pkg::MULT_W-1:0]  mult_r;
  logic [rqbn_pkg::SHIFT_W-1:0] shift_r;
  logic [rqbn_pkg::INT8_W-1:0]  zoff_r, clo_r, chi_r, olo_r, ohi_r;
  rqbn_pkg::rqbn_reg_t          reg_idx;
  logic                         cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = rqbn_pkg::rqbn_reg_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_r  <= rqbn_pkg::MULT_RST;
      shift_r <= rqbn_pkg::SHIFT_RST;
      zoff_r  <= rqbn_pkg::ZOFF_RST;
      clo_r   <= rqbn_pkg::LOW_RST;
      chi_r   <= rqbn_pkg::HIGH_RST;
      olo_r   <= rqbn_pkg::LOW_RST;
      ohi_r   <= rqbn_pkg::HIGH_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        rqbn_pkg::REG_MULT:  mult_r  <= cfg_pwdata[rqbn_pkg::MULT_W-1:0];
        rqbn_pkg::REG_SHIFT: shift_r <= cfg_pwdata[rqbn_pkg::SHIFT_W-1:0];
        rqbn_pkg::REG_ZOFF:  zoff_r  <= cfg_pwdata[rqbn_pkg::INT8_W-1:0];
        rqbn_pkg::REG_CLO:   clo_r   <= cfg_pwdata[rqbn_pkg::INT8_W-1:0];
        rqbn_pkg::REG_CHI:   chi_r   <= cfg_pwdata[rqbn_pkg::INT8_W-1:0];
        rqbn_pkg::REG_OLO:   olo_r   <= cfg_pwdata[rqbn_pkg::INT8_W-1:0];
        rqbn_pkg::REG_OHI:   ohi_r   <= cfg_pwdata[rqbn_pkg::INT8_W-1:0];
        default: ;  // unmapped address: write dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rqbn_pkg::REG_MULT:  cfg_prdata = rqbn_pkg::CFG_DW'(mult_r);
      rqbn_pkg::REG_SHIFT: cfg_prdata = rqbn_pkg::CFG_DW'(shift_r);
      rqbn_pkg::REG_ZOFF:  cfg_prdata = rqbn_pkg::CFG_DW'(zoff_r);
      rqbn_pkg::REG_CLO:   cfg_prdata = rqbn_pkg::CFG_DW'(clo_r);
      rqbn_pkg::REG_CHI:   cfg_prdata = rqbn_pkg::CFG_DW'(chi_r);
      rqbn_pkg::REG_OLO:   cfg_prdata = rqbn_pkg::CFG_DW'(olo_r);
      rqbn_pkg::REG_OHI:   cfg_prdata = rqbn_pkg::CFG_DW'(ohi_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // whole pipe moves together; the last valid bit is the output register's
  logic [rqbn_pkg::PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic                            adv;

  assign adv       = ~vld_r[rqbn_pkg::PIPE_DEPTH-1] | out_tready;
  assign in_tready = adv;
  assign vld_nxt   = {vld_r[rqbn_pkg::PIPE_DEPTH-2:0], in_tvalid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------- datapath ----------------
  logic signed [31:0] acc_in, gain_in, offs_in;
  assign acc_in  = $signed(in_tdata[31:0]);
  assign gain_in = $signed(in_tdata[63:32]);
  assign offs_in = $signed(in_tdata[95:64]);

  // gain and offset ride along until the batch-norm stages use them
  logic signed [31:0] gain1_r, gain2_r, gain3_r, gain4_r;
  logic signed [31:0] offs1_r, offs2_r, offs3_r, offs4_r, offs5_r;

  // stage 1: exact accumulator x Q31 multiplier
  logic signed [63:0] prod1_r, prod1_nxt;
  assign prod1_nxt = acc_in * $signed({1'b0, mult_r});

  // stage 2: round half up and drop 31 fraction bits; always fits 32 bits
  logic signed [63:0] rnd2;
  logic signed [31:0] scl2_r, scl2_nxt;
  assign rnd2     = prod1_r + 64'sh0000_0000_4000_0000;
  assign scl2_nxt = $signed(rnd2[62:31]);

  // stage 3: rounding right shift, or left shift wrapping at 32 bits
  logic               sh_pos, sh_neg;
  logic [4:0]         ramt;
  logic [5:0]         lamt;
  logic signed [32:0] radd, rshr;
  logic [31:0]        lshl;
  logic signed [32:0] scl3_r, scl3_nxt;

  assign sh_pos = ~shift_r[5] & (shift_r != '0);
  assign sh_neg = shift_r[5];
  assign ramt   = shift_r[4:0];
  assign lamt   = 6'd0 - shift_r;
  assign radd   = $signed({scl2_r[31], scl2_r}) + $signed(33'd1 << (ramt - 5'd1));
  assign rshr   = radd >>> ramt;
  assign lshl   = lamt[5] ? 32'd0 : (scl2_r << lamt[4:0]);  // shift of 32 gives zero

  always_comb begin
    if (sh_pos) begin
      scl3_nxt = rshr;
    end else if (sh_neg) begin
      scl3_nxt = $signed({lshl[31], lshl});
    end else begin
      scl3_nxt = $signed({scl2_r[31], scl2_r});
    end
  end

  // stage 4: zero offset, then low bound before high bound
  logic signed [33:0] zsum, zlo, clo_x, chi_x;
  logic [7:0]         conv4_r, conv4_nxt;

  assign zsum  = $signed({scl3_r[32], scl3_r}) + $signed({{26{zoff_r[7]}}, zoff_r});
  assign clo_x = $signed({{26{clo_r[7]}}, clo_r});
  assign chi_x = $signed({{26{chi_r[7]}}, chi_r});
  assign zlo   = (zsum < clo_x) ? clo_x : zsum;
  assign conv4_nxt = (zlo > chi_x) ? chi_r : zlo[7:0];

  // stage 5: conv value x gain
  logic signed [rqbn_pkg::BN_PROD_W-1:0] bnp5_r, bnp5_nxt;
  logic [7:0]                            conv5_r;
  assign bnp5_nxt = $signed(conv4_r) * gain4_r;

  // stage 6: add the channel offset
  logic signed [rqbn_pkg::BN_SUM_W-1:0] bns6_r, bns6_nxt;
  logic [7:0]                           conv6_r;
  assign bns6_nxt = $signed({bnp5_r[rqbn_pkg::BN_PROD_W-1], bnp5_r})
                  + $signed({{(rqbn_pkg::BN_SUM_W-32){offs5_r[31]}}, offs5_r});

  // stage 7: half away from zero is floor((s + h - neg) / 2^F), then clamp
  localparam logic [rqbn_pkg::BN_RND_W-1:0] HALF = rqbn_pkg::BN_RND_W'(1) << (F - 1);
  logic signed [rqbn_pkg::BN_RND_W-1:0] bnr7, bnq7, olo_x, ohi_x, olo7;
  logic [7:0]                           outv7_r, outv7_nxt, conv7_r;

  assign bnr7 = $signed({bns6_r[rqbn_pkg::BN_SUM_W-1], bns6_r}) + $signed(HALF)
              - $signed(rqbn_pkg::BN_RND_W'(bns6_r[rqbn_pkg::BN_SUM_W-1]));
  assign bnq7 = bnr7 >>> F;
  assign olo_x = $signed({{(rqbn_pkg::BN_RND_W-8){olo_r[7]}}, olo_r});
  assign ohi_x = $signed({{(rqbn_pkg::BN_RND_W-8){ohi_r[7]}}, ohi_r});
  assign olo7  = (bnq7 < olo_x) ? olo_x : bnq7;
  assign outv7_nxt = (olo7 > ohi_x) ? ohi_r : olo7[7:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      prod1_r <= prod1_nxt;
      gain1_r <= gain_in;
      offs1_r <= offs_in;
      scl2_r  <= scl2_nxt;
      gain2_r <= gain1_r;
      offs2_r <= offs1_r;
      scl3_r  <= scl3_nxt;
      gain3_r <= gain2_r;
      offs3_r <= offs2_r;
      conv4_r <= conv4_nxt;
      gain4_r <= gain3_r;
      offs4_r <= offs3_r;
      bnp5_r  <= bnp5_nxt;
      conv5_r <= conv4_r;
      offs5_r <= offs4_r;
      bns6_r  <= bns6_nxt;
      conv6_r <= conv5_r;
      outv7_r <= outv7_nxt;
      conv7_r <= conv6_r;
    end
  end

  assign out_tvalid = vld_r[rqbn_pkg::PIPE_DEPTH-1];
  assign out_tdata  = {outv7_r, conv7_r};

endmodule

### hdl/rqbn_checker.sv
module rqbn_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic [rqbn_pkg::OUT_DW-1:0]  out_tdata,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic                         cfg_pready
);

  // reset empties the pipe
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("item shown straight after reset");

  // input backpressure only ever comes from a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without an output stall");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("cfg_pready low");

endmodule

bind requant_batchnorm_epilogue_core rqbn_checker u_rqbn_checker (.*);

### tb/rqbn_epilogue_checker.sv
module rqbn_epilogue_checker
  import rqbn_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // accumulator [31:0], channel_gain [63:32], channel_offset [95:64]
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic              in_tvalid,
  input  logic              in_tready,
  // conv_value [7:0], out_value [15:8]
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int unsigned       mismatch_count,
  output int unsigned       awaited_results
);

  typedef struct packed {
    logic signed [INT8_W-1:0] bn_value;
    logic signed [INT8_W-1:0] conv_value;
  } epilogue_t;

  // shadow copy of the register file
  logic        [MULT_W-1:0]  mult_q;
  logic signed [SHIFT_W-1:0] shift_q;
  logic signed [INT8_W-1:0]  zoff_q;
  logic signed [INT8_W-1:0]  conv_lo_q;
  logic signed [INT8_W-1:0]  conv_hi_q;
  logic signed [INT8_W-1:0]  out_lo_q;
  logic signed [INT8_W-1:0]  out_hi_q;

  epilogue_t   predicted_epilogue_q[$];
  int unsigned fail_tally;
  int unsigned result_seq;

  assign mismatch_count  = fail_tally;
  assign awaited_results = predicted_epilogue_q.size();

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_tally++;
  endtask

  // low bound first, so crossed bounds resolve to the high one
  function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic epilogue_t requant_and_normalise(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [ACC_W-1:0] gain,
                                                      input logic signed [ACC_W-1:0] offs);
    longint      scaled;
    longint      conv;
    longint      bn_sum;
    longint      bn_res;
    longint      half;
    int          sh;
    logic [31:0] wrapped;
    epilogue_t   res;
    half   = longint'(1) <<< (GAIN_FRAC_BITS - 1);
    // Q31 multiply, rounded half up (floor shift)
    scaled = (longint'(acc) * longint'({1'b0, mult_q}) + (longint'(1) <<< 30)) >>> 31;
    sh     = shift_q;
    if (sh > 0) begin
      scaled = (scaled + (longint'(1) <<< (sh - 1))) >>> sh;
    end else if (sh < 0) begin
      // left shift wraps at 32 bits; 32 places leaves nothing
      wrapped = (-sh >= 32) ? 32'd0 : (32'(scaled) << (-sh));
      scaled  = longint'(signed'(wrapped));
    end
    conv   = clamp_range(scaled + longint'(zoff_q), longint'(conv_lo_q), longint'(conv_hi_q));
    bn_sum = conv * longint'(gain) + longint'(offs);
    // half away from zero
    if (bn_sum >= 0) begin
      bn_res = (bn_sum + half) >>> GAIN_FRAC_BITS;
    end else begin
      bn_res = -((-bn_sum + half) >>> GAIN_FRAC_BITS);
    end
    bn_res = clamp_range(bn_res, longint'(out_lo_q), longint'(out_hi_q));
    res.conv_value = 8'(conv);
    res.bn_value   = 8'(bn_res);
    return res;
  endfunction

  always @(posedge clk) begin
    epilogue_t want;
    epilogue_t got;
    if (!rst_n) begin
      mult_q    = MULT_RST;
      shift_q   = SHIFT_RST;
      zoff_q    = ZOFF_RST;
      conv_lo_q = LOW_RST;
      conv_hi_q = HIGH_RST;
      out_lo_q  = LOW_RST;
      out_hi_q  = HIGH_RST;
      predicted_epilogue_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (predicted_epilogue_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing outstanding", result_seq));
        end else begin
          want = predicted_epilogue_q.pop_front();
          if (got.conv_value !== want.conv_value)
            report_mismatch($sformatf("result %0d conv_value %0d, predicted %0d",
                                      result_seq, got.conv_value, want.conv_value));
          if (got.bn_value !== want.bn_value)
            report_mismatch($sformatf("result %0d out_value %0d, predicted %0d",
                                      result_seq, got.bn_value, want.bn_value));
        end
        result_seq++;
      end
      if (in_tvalid && in_tready)
        predicted_epilogue_q.push_back(requant_and_normalise(in_tdata[31:0], in_tdata[63:32],
                                                             in_tdata[95:64]));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_MULT:  mult_q    = cfg_pwdata[MULT_W-1:0];
          REG_SHIFT: shift_q   = cfg_pwdata[SHIFT_W-1:0];
          REG_ZOFF:  zoff_q    = cfg_pwdata[INT8_W-1:0];
          REG_CLO:   conv_lo_q = cfg_pwdata[INT8_W-1:0];
          REG_CHI:   conv_hi_q = cfg_pwdata[INT8_W-1:0];
          REG_OLO:   out_lo_q  = cfg_pwdata[INT8_W-1:0];
          REG_OHI:   out_hi_q  = cfg_pwdata[INT8_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/requant_batchnorm_epilogue_core_test.sv
module requant_batchnorm_epilogue_core_test;
  import rqbn_pkg::*;

  // cycles without any item moving before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned NUM_PHASES       = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 98;
  // index past the register file; a write there must change nothing
  localparam int unsigned UNUSED_REG_INDEX = 7;

  typedef struct {
    logic [MULT_W-1:0]  mult;
    logic [SHIFT_W-1:0] shift;
    logic [INT8_W-1:0]  zoff;
    logic [INT8_W-1:0]  conv_lo;
    logic [INT8_W-1:0]  conv_hi;
    logic [INT8_W-1:0]  out_lo;
    logic [INT8_W-1:0]  out_hi;
  } reg_setting_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic [IN_DW-1:0]  in_tdata    = '0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int unsigned mismatch_count;
  int unsigned awaited_results;
  int unsigned quiet_cycles = 0;
  // per-cycle odds (out of 100) of the sender idling / the receiver stalling
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  always #5 clk = ~clk;

  requant_batchnorm_epilogue_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  rqbn_epilogue_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tdata        (in_tdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .out_tdata       (out_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .mismatch_count  (mismatch_count),
    .awaited_results (awaited_results)
  );

  // Receiver: a fresh stall decision every cycle, on the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: restarted by any item moving on either stream.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // APB write. Bits outside the register's width carry noise, the block has to
  // drop them.
  task automatic write_register(input int unsigned index, input logic [31:0] value,
                                input logic [31:0] keep_mask);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(index * 4);
    cfg_pwdata  <= (value & keep_mask) | ($urandom & ~keep_mask);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic apply_setting(input reg_setting_t s);
    write_register(REG_MULT,  32'(s.mult),    32'h7FFF_FFFF);
    write_register(REG_SHIFT, 32'(s.shift),   32'h0000_003F);
    write_register(REG_ZOFF,  32'(s.zoff),    32'h0000_00FF);
    write_register(REG_CLO,   32'(s.conv_lo), 32'h0000_00FF);
    write_register(REG_CHI,   32'(s.conv_hi), 32'h0000_00FF);
    write_register(REG_OLO,   32'(s.out_lo),  32'h0000_00FF);
    write_register(REG_OHI,   32'(s.out_hi),  32'h0000_00FF);
  endtask

  // One item: random idle cycles first (valid low), then hold until taken.
  task automatic send_item(input logic [31:0] acc, input logic [31:0] gain,
                           input logic [31:0] offs);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {offs, gain, acc};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Sender holds off until every outstanding result has been taken.
  task automatic drain_pipeline();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results != 0) @(negedge clk);
  endtask

  // Log-uniform magnitude: mostly small values, but full-width ones (every
  // bit free) whenever the shift comes out as zero.
  function automatic logic [31:0] log_spread();
    return $signed($urandom) >>> $urandom_range(31, 0);
  endfunction

  function automatic reg_setting_t phase_setting(input int unsigned phase);
    reg_setting_t s;
    case (phase)
      // widest multiplier with the widest rounding right shift
      1: s = '{31'h7FFF_FFFF, 6'(31), 8'sd127, -8'sd128, 8'sd127, -8'sd128, 8'sd127};
      // zero multiplier, widest legal left shift
      2: s = '{31'd0, 6'(-31), -8'sd128, -8'sd128, 8'sd127, -8'sd128, 8'sd127};
      // left shift of 32 (always zero), crossed conv clamp
      3: s = '{31'h4000_0000, 6'(-32), 8'sd5, 8'sd100, -8'sd100, -8'sd128, 8'sd127};
      // crossed output clamp
      4: s = '{31'h5A5A_5A5A, 6'(7), -8'sd3, -8'sd50, 8'sd60, 8'sd127, -8'sd128};
      5: s = '{31'h0001_2345, 6'(-4), 8'sd0, -8'sd128, 8'sd127, -8'sd20, 8'sd20};
      6: s = '{31'h7FFF_FFFF, 6'(1), 8'sd0, -8'sd128, 8'sd127, -8'sd128, 8'sd127};
      default: begin
        s.mult    = MULT_W'($urandom);
        s.shift   = SHIFT_W'($urandom);
        s.zoff    = INT8_W'($urandom);
        s.conv_lo = INT8_W'($urandom);
        s.conv_hi = INT8_W'($urandom);
        s.out_lo  = INT8_W'($urandom);
        s.out_hi  = INT8_W'($urandom);
      end
    endcase
    return s;
  endfunction

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed items on the reset setting (multiplier one half, no shift,
    // no zero offset, full clamps).
    send_item(32'd0, 32'd0, 32'd0);
    send_item(32'd1, 32'h0001_0000, 32'd0);          // Q31 tie, rounds up to 1
    send_item(32'hFFFF_FFFF, 32'h0001_0000, 32'd0);  // -0.5 rounds up to 0
    send_item(32'hFFFF_FFFD, 32'h0001_0000, 32'd0);  // -1.5 rounds up to -1
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(32'd0, 32'd0, 32'h0000_8000);          // +0.5, away from zero
    send_item(32'd0, 32'd0, 32'hFFFF_8000);          // -0.5, away from zero
    send_item(32'd0, 32'd0, 32'h0000_7FFF);
    send_item(32'd0, 32'd0, 32'hFFFF_8001);
    send_item(32'd2, 32'hFFFE_8000, 32'd0);          // -1.5 -> -2
    send_item(32'd200, 32'h0001_8000, 32'd0);        // output clamps high
    send_item(32'd254, 32'h0000_8000, 32'd0);        // 63.5 -> 64
    send_item(32'hFFFF_FF00, 32'hFFFF_0000, 32'd0);  // -128 * -1 clamps to 127
    send_item(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF);
    send_item(32'd0, 32'd0, 32'h8000_0000);
    send_item(32'h0000_0100, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase != 0) begin
        // registers change only with the pipeline empty
        drain_pipeline();
        if (phase == 4) write_register(UNUSED_REG_INDEX, $urandom, 32'hFFFF_FFFF);
        apply_setting(phase_setting(phase));
      end
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++)
        send_item(log_spread(), log_spread(), log_spread());
    end

    drain_pipeline();
    // room for any stray result behind the last expected one
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
